/* hdl/delimited_command_tokenizer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Delimited command tokenizer assertion macros
// Concurrent assertion shorthands; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_COMMAND_TOKENIZER_UNIT_ASSERT_SVH
`define DELIMITED_COMMAND_TOKENIZER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DCTU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DCTU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define DCTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/dct_pkg.sv */
// ----------------------------------------------------------------------------
// Delimited command tokenizer package
// Scanner phases, token kinds, character codes, item structs and classifiers.
// ----------------------------------------------------------------------------
package dct_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BEGIN = 3'd1,
    PH_ANY   = 3'd2,
    PH_REF   = 3'd3,
    PH_CMD   = 3'd4,
    PH_WORD  = 3'd5,
    PH_EOL   = 3'd6,
    PH_CONT  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_CMD   = 3'd2,
    KIND_REF   = 3'd3,
    KIND_WORD  = 3'd4,
    KIND_END   = 3'd5
  } kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
    logic [7:0] close_char;
  } in_item_t;

  typedef struct packed {
    logic [1:0] emit_count;
    logic [7:0] emit_first;
    logic [7:0] emit_second;
    logic       token_done;
    kind_t      token_kind;
    logic       consumed;
  } out_item_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
  endfunction

  function automatic logic is_space_any(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE) || (c == CH_LT);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE) || (c == CH_GT);
  endfunction

endpackage

/* hdl/dct_if.sv */
// ----------------------------------------------------------------------------
// Delimited command tokenizer channels
// Valid/ready interfaces for the character stream and the token result stream.
// ----------------------------------------------------------------------------
interface dct_in_if
  import dct_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;
  logic [7:0] close_char;

  modport source (output valid, output ch, output at_end, output close_char, input ready);
  modport sink   (input valid, input ch, input at_end, input close_char, output ready);
endinterface

interface dct_out_if
  import dct_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] emit_count;
  logic [7:0] emit_first;
  logic [7:0] emit_second;
  logic       token_done;
  kind_t      token_kind;
  logic       consumed;

  modport source (output valid, output emit_count, output emit_first, output emit_second,
                  output token_done, output token_kind, output consumed, input ready);
  modport sink   (input valid, input emit_count, input emit_first, input emit_second,
                  input token_done, input token_kind, input consumed, output ready);
endinterface

/* hdl/dct_in_stage.sv */
// ----------------------------------------------------------------------------
// Delimited command tokenizer input stage
// Input register; holds one item until the scanner takes it.
// ----------------------------------------------------------------------------
module dct_in_stage
  import dct_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  dct_in_if.sink       in_chan,
  input  logic         take,
  output logic         item_valid,
  output in_item_t     item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_chan.ready = !valid_r || take;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{ch: in_chan.ch, at_end: in_chan.at_end, close_char: in_chan.close_char};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* hdl/dct_step.sv */
// ----------------------------------------------------------------------------
// Delimited command tokenizer scan step
// One scanner step: result item and next phase for the registered character.
// ----------------------------------------------------------------------------
module dct_step
  import dct_pkg::*;
(
  input  phase_t     phase,
  input  logic [7:0] exp_close,
  input  in_item_t   item,
  output phase_t     phase_nxt,
  output logic [7:0] exp_close_nxt,
  output out_item_t  res
);

  phase_t     ph0;
  logic [7:0] c;
  logic       closes;

  // A step taken with no token open starts one and latches its delimiter.
  always_comb begin
    c = item.ch;
    if (phase == PH_IDLE) begin
      exp_close_nxt = item.close_char;
      ph0           = (item.close_char == CH_NUL) ? PH_BEGIN : PH_ANY;
    end else begin
      exp_close_nxt = exp_close;
      ph0           = phase;
    end
    closes = is_closer(c) && (c == exp_close_nxt);
  end

  // Result item.
  always_comb begin
    res = '{emit_count: 2'd0, emit_first: CH_NUL, emit_second: CH_NUL,
            token_done: 1'b0, token_kind: KIND_OPEN, consumed: 1'b1};
    if (item.at_end) begin
      res.token_done = 1'b1;
      res.token_kind = KIND_END;
    end else begin
      case (ph0)
        PH_BEGIN: begin
          if (c == CH_BAR) begin
            res.token_done = 1'b1;
            res.token_kind = KIND_CMD;
            res.consumed   = 1'b0;
          end else if (is_opener(c)) begin
            res.emit_count = 2'd1;
            res.emit_first = c;
            res.token_done = 1'b1;
            res.token_kind = KIND_OPEN;
          end else if (!is_blank(c)) begin
            res.emit_count = 2'd1;
            res.emit_first = c;
          end
        end
        PH_ANY: begin
          if (!is_blank(c)) begin
            res.emit_count = 2'd1;
            res.emit_first = c;
            if ((c != CH_PCT) && closes) begin
              res.token_done = 1'b1;
              res.token_kind = KIND_CLOSE;
            end
          end
        end
        PH_CMD: begin
          if ((c == CH_BAR) || is_blank(c) || is_opener(c)) begin
            res.token_done = 1'b1;
            res.token_kind = KIND_CMD;
            res.consumed   = 1'b0;
          end else begin
            res.emit_count = 2'd1;
            res.emit_first = c;
          end
        end
        PH_WORD: begin
          if (is_blank(c) || (c == CH_PCT) || closes) begin
            res.token_done = 1'b1;
            res.token_kind = KIND_WORD;
            res.consumed   = 1'b0;
          end else begin
            res.emit_count = 2'd1;
            res.emit_first = c;
          end
        end
        PH_REF: begin
          if ((c == CH_NL) || (c == CH_BSLASH)) begin
            res.emit_count = 2'd0;
          end else if (closes) begin
            res.emit_count = 2'd1;
            res.emit_first = CH_NL;
            res.token_done = 1'b1;
            res.token_kind = KIND_REF;
            res.consumed   = 1'b0;
          end else begin
            res.emit_count = 2'd1;
            res.emit_first = c;
          end
        end
        PH_CONT: begin
          if (c != CH_NL) begin
            res.emit_count  = 2'd2;
            res.emit_first  = CH_BSLASH;
            res.emit_second = c;
          end
        end
        PH_EOL: begin
          res.consumed = 1'b0;
          if (c == CH_PCT) begin
            res.emit_count = 2'd1;
            res.emit_first = CH_NL;
            res.token_done = 1'b1;
            res.token_kind = KIND_REF;
          end else if (!is_space_any(c)) begin
            res.emit_count = 2'd1;
            res.emit_first = CH_SPACE;
          end
        end
        default: begin
          res.consumed = 1'b1;
        end
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = ph0;
    if (item.at_end || res.token_done) begin
      phase_nxt = PH_IDLE;
    end else begin
      case (ph0)
        PH_BEGIN: phase_nxt = is_blank(c) ? PH_BEGIN : PH_CMD;
        PH_ANY: begin
          if (is_blank(c)) begin
            phase_nxt = PH_ANY;
          end else if (c == CH_PCT) begin
            phase_nxt = PH_REF;
          end else begin
            phase_nxt = PH_WORD;
          end
        end
        PH_REF: begin
          if (c == CH_NL) begin
            phase_nxt = PH_EOL;
          end else if (c == CH_BSLASH) begin
            phase_nxt = PH_CONT;
          end else begin
            phase_nxt = PH_REF;
          end
        end
        PH_CONT: phase_nxt = PH_REF;
        PH_EOL:  phase_nxt = PH_REF;
        default: phase_nxt = ph0;
      endcase
    end
  end

endmodule

/* hdl/delimited_command_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// Delimited command tokenizer unit
// Character-level lexer for a bar-command markup language, one char per clock while out_chan is not stalled.
// ----------------------------------------------------------------------------
//
//   channel   direction  item
//   in_chan   sink       ch, at_end, close_char
//   out_chan  source     emit_count, emit_first, emit_second, token_done,
//                        token_kind, consumed
//
// One item per clock sustained while out_chan is not stalled; an accepted item
// is held in the input register, and its result is then registered in the
// result register. The scanner phase register feeds back into the one-step
// logic each time an item advances, so that loop sets the rate.
// Reset clears the phase to idle, the latched delimiter to zero and both
// valid flags. A stalled result holds both stages; the input stage refills
// as soon as its item moves into the result register.
//
`include "delimited_command_tokenizer_unit_assert.svh"

module delimited_command_tokenizer_unit
  import dct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dct_in_if.sink     in_chan,
  dct_out_if.source  out_chan
);

  // Input register stage.
  logic      item_valid;
  in_item_t  item;
  logic      advance;

  // Scanner state.
  phase_t     phase_r;
  phase_t     phase_nxt;
  logic [7:0] exp_close_r;
  logic [7:0] exp_close_nxt;

  // Result register.
  out_item_t res;
  out_item_t res_r;
  logic      out_valid_r;
  logic      out_valid_nxt;

  // Advance whenever the result register is free or being emptied.
  assign advance = !out_valid_r || out_chan.ready;

  dct_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dct_step u_step (
    .phase         (phase_r),
    .exp_close     (exp_close_r),
    .item          (item),
    .phase_nxt     (phase_nxt),
    .exp_close_nxt (exp_close_nxt),
    .res           (res)
  );

  always_comb begin
    out_valid_nxt = advance ? item_valid : out_valid_r;
  end

  // Update the scanner only when its item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      exp_close_r <= CH_NUL;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance && item_valid) begin
        phase_r     <= phase_nxt;
        exp_close_r <= exp_close_nxt;
      end
    end
  end

  // Hold the result payload while stalled.
  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.emit_count  = res_r.emit_count;
  assign out_chan.emit_first  = res_r.emit_first;
  assign out_chan.emit_second = res_r.emit_second;
  assign out_chan.token_done  = res_r.token_done;
  assign out_chan.token_kind  = res_r.token_kind;
  assign out_chan.consumed    = res_r.consumed;

  // End of input always drops the scanner back to idle.
  `DCTU_ASSERT_NEXT(a_end_idles, clk, rst_n, advance && item_valid && item.at_end, phase_r == PH_IDLE, "end of input did not return scanner to idle")

  // Unused emit slots read as zero.
  `DCTU_ASSERT_SAME(a_emit_zero, clk, rst_n, out_valid_r && (res_r.emit_count == 2'd0), (res_r.emit_first == CH_NUL) && (res_r.emit_second == CH_NUL), "unused emit slot not zero")

  // A two-character emit only comes from a line join and never ends a token.
  `DCTU_ASSERT_SAME(a_pair_open, clk, rst_n, out_valid_r && (res_r.emit_count == 2'd2), !res_r.token_done && (res_r.emit_first == CH_BSLASH), "bad two-character emit")

  // A stalled result keeps the scanner state frozen.
  `DCTU_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid_r && !out_chan.ready, $stable(phase_r) && $stable(exp_close_r), "scanner state moved during stall")

endmodule

/* tb/sv/delimited_command_tokenizer_unit_checker.sv */
// ----------------------------------------------------------------------------
// Delimited command tokenizer checker
// Watches both channels, predicts each token result from the accepted
// characters and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module delimited_command_tokenizer_unit_checker
  import dct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dct_in_if           in_chan,
  dct_out_if          out_chan,
  output int unsigned fail_count,
  output int unsigned pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LINES = 60;

  // Scanner copy: phase and the delimiter latched at token start
  phase_t     lex_phase;
  logic [7:0] lex_close;

  out_item_t  token_q [$];
  out_item_t  got;
  out_item_t  want;
  in_item_t   taken;
  int unsigned result_idx;

  initial begin
    fail_count = 0;
    pending    = 0;
    result_idx = 0;
  end

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h09;
  endfunction

  function automatic logic white_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic open_bracket(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE || c == CH_LT;
  endfunction

  function automatic logic ends_group(input logic [7:0] c, input logic [7:0] want_close);
    logic closer;
    closer = c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE || c == CH_GT;
    return closer && c == want_close;
  endfunction

  // Advance the scanner by one character and return the token result.
  function automatic out_item_t lex_next(input in_item_t it);
    out_item_t  r;
    phase_t     ph;
    logic [7:0] c;
    r          = '0;
    r.consumed = 1'b1;
    c          = it.ch;
    ph         = lex_phase;
    if (ph == PH_IDLE) begin
      lex_close = it.close_char;
      ph = (it.close_char == 8'h00) ? PH_BEGIN : PH_ANY;
    end
    if (it.at_end) begin
      r.token_done = 1'b1;
      r.token_kind = KIND_END;
      ph           = PH_IDLE;
    end else begin
      case (ph)
        PH_BEGIN: begin
          if (c == CH_BAR) begin
            r.token_done = 1'b1;
            r.token_kind = KIND_CMD;
            r.consumed   = 1'b0;
          end else if (open_bracket(c)) begin
            r.emit_count = 2'd1;
            r.emit_first = c;
            r.token_done = 1'b1;
            r.token_kind = KIND_OPEN;
          end else if (!blank_char(c)) begin
            r.emit_count = 2'd1;
            r.emit_first = c;
            ph           = PH_CMD;
          end
        end
        PH_ANY: begin
          if (!blank_char(c)) begin
            r.emit_count = 2'd1;
            r.emit_first = c;
            if (c == CH_PCT) begin
              ph = PH_REF;
            end else if (ends_group(c, lex_close)) begin
              r.token_done = 1'b1;
              r.token_kind = KIND_CLOSE;
            end else begin
              ph = PH_WORD;
            end
          end
        end
        PH_CMD: begin
          if (c == CH_BAR || blank_char(c) || open_bracket(c)) begin
            r.token_done = 1'b1;
            r.token_kind = KIND_CMD;
            r.consumed   = 1'b0;
          end else begin
            r.emit_count = 2'd1;
            r.emit_first = c;
          end
        end
        PH_WORD: begin
          if (blank_char(c) || c == CH_PCT || ends_group(c, lex_close)) begin
            r.token_done = 1'b1;
            r.token_kind = KIND_WORD;
            r.consumed   = 1'b0;
          end else begin
            r.emit_count = 2'd1;
            r.emit_first = c;
          end
        end
        PH_REF: begin
          if (c == CH_NL) begin
            ph = PH_EOL;
          end else if (c == CH_BSLASH) begin
            ph = PH_CONT;
          end else if (ends_group(c, lex_close)) begin
            r.emit_count = 2'd1;
            r.emit_first = CH_NL;
            r.token_done = 1'b1;
            r.token_kind = KIND_REF;
            r.consumed   = 1'b0;
          end else begin
            r.emit_count = 2'd1;
            r.emit_first = c;
          end
        end
        PH_CONT: begin
          ph = PH_REF;
          if (c != CH_NL) begin
            r.emit_count  = 2'd2;
            r.emit_first  = CH_BSLASH;
            r.emit_second = c;
          end
        end
        default: begin
          r.consumed = 1'b0;
          if (c == CH_PCT) begin
            r.emit_count = 2'd1;
            r.emit_first = CH_NL;
            r.token_done = 1'b1;
            r.token_kind = KIND_REF;
          end else begin
            if (!white_char(c)) begin
              r.emit_count = 2'd1;
              r.emit_first = CH_SPACE;
            end
            ph = PH_REF;
          end
        end
      endcase
      if (r.token_done) ph = PH_IDLE;
    end
    lex_phase = ph;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_LINES) $display("[%0t] result %0d: %s", $realtime, result_idx, msg);
    fail_count++;
  endtask

  // Compare as four-state bytes so an unknown output bit never matches.
  task automatic field_check(input string name, input logic [7:0] g, input logic [7:0] w);
    if (g !== w) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, g, w));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_phase = PH_IDLE;
      lex_close = 8'h00;
      token_q.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.emit_count  = out_chan.emit_count;
        got.emit_first  = out_chan.emit_first;
        got.emit_second = out_chan.emit_second;
        got.token_done  = out_chan.token_done;
        got.token_kind  = out_chan.token_kind;
        got.consumed    = out_chan.consumed;
        if (token_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = token_q.pop_front();
          field_check("emit_count", 8'(got.emit_count), 8'(want.emit_count));
          field_check("emit_first", got.emit_first, want.emit_first);
          field_check("emit_second", got.emit_second, want.emit_second);
          field_check("token_done", 8'(got.token_done), 8'(want.token_done));
          field_check("token_kind", 8'(got.token_kind), 8'(want.token_kind));
          field_check("consumed", 8'(got.consumed), 8'(want.consumed));
        end
        result_idx++;
      end
      if (in_chan.valid && in_chan.ready) begin
        taken.ch         = in_chan.ch;
        taken.at_end     = in_chan.at_end;
        taken.close_char = in_chan.close_char;
        token_q.push_back(lex_next(taken));
      end
    end
    pending <= token_q.size();
  end

endmodule

/* tb/sv/delimited_command_tokenizer_unit_test.sv */
// ----------------------------------------------------------------------------
// Delimited command tokenizer testbench
// Drives directed and random character streams through the tokenizer under
// varying sender and receiver idling; a checker beside the block predicts
// and compares every token result.
// ----------------------------------------------------------------------------
module delimited_command_tokenizer_unit_test
  import dct_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_ITEMS = 430;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned DRAIN_WAIT  = 10;

  logic clk;
  logic rst_n;

  dct_in_if  in_chan ();
  dct_out_if out_chan ();

  int unsigned fail_count;
  int unsigned pending;

  // Idle chances in percent; the sender one is read only by the stimulus
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  // Long receiver hold-off: bump the request count, the receiver does the rest
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  int unsigned sent;

  delimited_command_tokenizer_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  delimited_command_tokenizer_unit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random ready at each falling edge, or a long hold when asked.
  initial begin
    out_chan.ready = 1'b0;
    hold_seen      = 0;
    hold_left      = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_req) begin
        // start the stretch: hold ready low until hold_left runs out
        hold_seen = hold_req;
        hold_left = LONG_HOLD - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offer one item at a falling edge and hold it until it is taken.
  // Returns at the falling edge after acceptance, so back-to-back items
  // keep valid high without a second assignment in the same step.
  task automatic send_item(input logic [7:0] c, input logic e, input logic [7:0] cc);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.ch         <= c;
    in_chan.at_end     <= e;
    in_chan.close_char <= cc;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] any_closer();
    case ($urandom_range(3))
      0:       return CH_RPAREN;
      1:       return CH_RBRACK;
      2:       return CH_RBRACE;
      default: return CH_GT;
    endcase
  endfunction

  function automatic logic [7:0] any_opener();
    case ($urandom_range(3))
      0:       return CH_LPAREN;
      1:       return CH_LBRACK;
      2:       return CH_LBRACE;
      default: return CH_LT;
    endcase
  endfunction

  // Pick a text-like character; delimiters, percent signs, backslashes and
  // newlines are weighted up so every scanner phase is visited often.
  function automatic logic [7:0] text_char(input logic [7:0] delim);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return 8'h61 + 8'($urandom_range(25));
    if (r < 40) return CH_SPACE;
    if (r < 47) return CH_NL;
    if (r < 50) return CH_TAB;
    if (r < 56) return CH_BAR;
    if (r < 62) return any_opener();
    if (r < 70) return (delim != 8'h00) ? delim : any_closer();
    if (r < 73) return any_closer();
    if (r < 81) return CH_PCT;
    if (r < 86) return CH_BSLASH;
    if (r < 89) return 8'h0B + 8'($urandom_range(2));
    return 8'($urandom_range(255));
  endfunction

  // One phrase: a run of characters under one delimiter choice, mostly
  // well-formed text, sometimes noise, now and then cut by end of input.
  task automatic send_phrase();
    logic [7:0]  delim;
    logic [7:0]  c;
    logic [7:0]  cc;
    int unsigned len;
    int unsigned r;
    r = $urandom_range(9);
    if (r < 3)      delim = 8'h00;
    else if (r < 9) delim = any_closer();
    else            delim = 8'($urandom_range(255));
    len = $urandom_range(20, 3);
    repeat (len) begin
      c  = ($urandom_range(99) < 85) ? text_char(delim) : 8'($urandom_range(255));
      cc = ($urandom_range(99) < 85) ? delim : 8'($urandom_range(255));
      send_item(c, ($urandom_range(99) < 2), cc);
    end
    if ($urandom_range(99) < 15) send_item(8'($urandom_range(255)), 1'b1, delim);
  endtask

  task automatic run_phrases(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = sent + n_items;
    while (sent < stop_at) send_phrase();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.ch         = 8'h00;
    in_chan.at_end     = 1'b0;
    in_chan.close_char = 8'h00;
    src_idle_pct       = 31;
    sink_idle_pct      = 74;
    hold_req           = 0;
    sent               = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: command mode, bar at token start, pushback on opener
    send_item(CH_BAR, 1'b0, 8'h00);
    send_item(CH_SPACE, 1'b0, 8'h00);
    send_item("i", 1'b0, CH_RPAREN);     // delimiter mid-token is ignored
    send_item("f", 1'b0, 8'h00);
    send_item(CH_LPAREN, 1'b0, 8'h00);
    send_item(CH_LPAREN, 1'b0, 8'h00);
    // Reference line with joined lines, a folded newline and a closer
    send_item(CH_PCT, 1'b0, CH_RPAREN);
    send_item("x", 1'b0, 8'h00);
    send_item(CH_BSLASH, 1'b0, 8'h00);
    send_item(CH_NL, 1'b0, 8'h00);
    send_item(CH_BSLASH, 1'b0, 8'h00);
    send_item("q", 1'b0, 8'h00);
    send_item(CH_NL, 1'b0, 8'h00);
    send_item("y", 1'b0, 8'h00);
    send_item(CH_NL, 1'b0, 8'h00);
    send_item(CH_CR, 1'b0, 8'h00);
    send_item(CH_RPAREN, 1'b0, 8'h00);
    send_item(CH_RPAREN, 1'b0, CH_RPAREN);
    // Newline then percent ends the reference line
    send_item(CH_PCT, 1'b0, CH_RBRACE);
    send_item(CH_NL, 1'b0, 8'h00);
    send_item(CH_PCT, 1'b0, 8'h00);
    // Word cut by its closer, then the close token
    send_item("w", 1'b0, CH_RBRACK);
    send_item(CH_RBRACK, 1'b0, 8'h00);
    send_item(CH_RBRACK, 1'b0, CH_RBRACK);
    // Odd delimiter never closes; zero byte is plain text; end abandons
    send_item(8'h00, 1'b0, 8'h61);
    send_item(8'h61, 1'b0, 8'hFF);
    send_item(8'hFF, 1'b1, 8'hFF);
    send_item(8'hFF, 1'b0, 8'h00);
    send_item(CH_GT, 1'b0, 8'h00);
    send_item(8'h00, 1'b1, 8'h00);

    run_phrases(PHASE_ITEMS);

    src_idle_pct  = 74;
    sink_idle_pct <= 31;
    run_phrases(PHASE_ITEMS);

    // No idling; stall the receiver for a long stretch while items keep coming
    src_idle_pct  = 0;
    sink_idle_pct <= 0;
    hold_req      <= hold_req + 1;
    run_phrases(PHASE_ITEMS);

    in_chan.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/dct_pkg.sv
hdl/dct_if.sv
hdl/dct_in_stage.sv
hdl/dct_step.sv
hdl/delimited_command_tokenizer_unit.sv
tb/sv/delimited_command_tokenizer_unit_checker.sv
tb/sv/delimited_command_tokenizer_unit_test.sv
